// ===== design/alet_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency list edge table package
// Shared widths, status and register codes, sequencer states and the
// control word that steers the table memories.
// ----------------------------------------------------------------------------
package alet_pkg;

  // Fixed field widths of the request, response and configuration words
  localparam int VTX_W    = 6;
  localparam int WEIGHT_W = 32;
  localparam int VCNT_W   = 7;
  localparam int MDEG_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEGREE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED     = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_DRD   = 9'b000001000,
    S_DCHK  = 9'b000010000,
    S_SRCH  = 9'b000100000,
    S_MRD   = 9'b001000000,
    S_MWR   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  // Write strobes toward the table memories
  typedef struct packed {
    logic deg_we;
    logic nb_we;
    logic wt_we;
  } mem_ctl_t;

endpackage

// ===== design/alet_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge request channel
// Valid/ready channel carrying one insert or remove request word.
// ----------------------------------------------------------------------------
interface alet_req_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [alet_pkg::VTX_W-1:0]        source_vtx;
  logic [alet_pkg::VTX_W-1:0]        target;
  logic                              directed;
  logic signed [alet_pkg::WEIGHT_W-1:0] weight;

  modport source (
    output valid, kind, source_vtx, target, directed, weight,
    input  ready
  );
  modport sink (
    input  valid, kind, source_vtx, target, directed, weight,
    output ready
  );
endinterface

// ===== design/alet_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge response channel
// Valid/ready channel carrying the status word of one request.
// ----------------------------------------------------------------------------
interface alet_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] mirror_status;

  modport source (
    output valid, status, mirror_status,
    input  ready
  );
  modport sink (
    input  valid, status, mirror_status,
    output ready
  );
endinterface

// ===== design/alet_tables.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency list tables
// Degree, neighbor and weight memories, one write and one registered read
// port each; neighbor and weight share the read address.
// ----------------------------------------------------------------------------
module alet_tables #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                                clk_i,
  input  alet_pkg::mem_ctl_t                  ctl_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]     deg_waddr_i,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]     deg_wdata_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]     deg_raddr_i,
  output logic [$clog2(MAX_DEGREE+1)-1:0]     deg_rdata_o,
  input  logic [$clog2(MAX_VERTICES*MAX_DEGREE)-1:0] nb_waddr_i,
  input  logic [alet_pkg::VTX_W-1:0]          nb_wdata_i,
  input  logic [alet_pkg::WEIGHT_W-1:0]       wt_wdata_i,
  input  logic [$clog2(MAX_VERTICES*MAX_DEGREE)-1:0] nb_raddr_i,
  output logic [alet_pkg::VTX_W-1:0]          nb_rdata_o,
  output logic [alet_pkg::WEIGHT_W-1:0]       wt_rdata_o
);

  localparam int DW    = $clog2(MAX_DEGREE + 1);
  localparam int SLOTS = MAX_VERTICES * MAX_DEGREE;

  logic [DW-1:0]                 deg_mem [MAX_VERTICES];
  logic [alet_pkg::VTX_W-1:0]    nb_mem  [SLOTS];
  logic [alet_pkg::WEIGHT_W-1:0] wt_mem  [SLOTS];

  // Degree memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.deg_we) begin
      deg_mem[deg_waddr_i] <= deg_wdata_i;
    end
    deg_rdata_o <= deg_mem[deg_raddr_i];
  end

  // Neighbor memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.nb_we) begin
      nb_mem[nb_waddr_i] <= nb_wdata_i;
    end
    nb_rdata_o <= nb_mem[nb_raddr_i];
  end

  // Weight memory
  always_ff @(posedge clk_i) begin
    if (ctl_i.wt_we) begin
      wt_mem[nb_waddr_i] <= wt_wdata_i;
    end
    wt_rdata_o <= wt_mem[nb_raddr_i];
  end

endmodule

// ===== design/alet_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency list sequencer
// Runs one request at a time: range check, degree lookup, append or a
// one-slot-per-cycle neighbor search with swap-with-last removal, then the
// mirror edge of an undirected request, and holds the result word in an output register.
// ----------------------------------------------------------------------------
module alet_seq #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic [alet_pkg::VCNT_W-1:0]         vcount_i,
  input  logic [alet_pkg::MDEG_W-1:0]         mdeg_i,
  input  logic                                weighted_i,
  // request word
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [alet_pkg::VTX_W-1:0]          source_i,
  input  logic [alet_pkg::VTX_W-1:0]          target_i,
  input  logic                                directed_i,
  input  logic [alet_pkg::WEIGHT_W-1:0]       weight_i,
  // response word
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output alet_pkg::status_e                   status_o,
  output alet_pkg::status_e                   mirror_status_o,
  // table access
  output alet_pkg::mem_ctl_t                  ctl_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     deg_waddr_o,
  output logic [$clog2(MAX_DEGREE+1)-1:0]     deg_wdata_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     deg_raddr_o,
  input  logic [$clog2(MAX_DEGREE+1)-1:0]     deg_rdata_i,
  output logic [$clog2(MAX_VERTICES*MAX_DEGREE)-1:0] nb_waddr_o,
  output logic [alet_pkg::VTX_W-1:0]          nb_wdata_o,
  output logic [alet_pkg::WEIGHT_W-1:0]       wt_wdata_o,
  output logic [$clog2(MAX_VERTICES*MAX_DEGREE)-1:0] nb_raddr_o,
  input  logic [alet_pkg::VTX_W-1:0]          nb_rdata_i,
  input  logic [alet_pkg::WEIGHT_W-1:0]       wt_rdata_i
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int AW = $clog2(MAX_VERTICES * MAX_DEGREE);

  alet_pkg::state_e  state_q, state_d;
  alet_pkg::status_e st_q, st_d, mst_q, mst_d;
  alet_pkg::status_e out_st_q, out_st_d, out_mst_q, out_mst_d;
  alet_pkg::status_e op_st;

  logic                          kind_q, kind_d;
  logic [alet_pkg::VTX_W-1:0]    src_q, src_d, dst_q, dst_d, to_q, to_d;
  logic                          dir_q, dir_d;
  logic [alet_pkg::WEIGHT_W-1:0] wt_q, wt_d;
  logic                          phase_q, phase_d;
  logic [VW-1:0]                 from_q, from_d, clr_q, clr_d;
  logic [AW-1:0]                 base_q, base_d;
  logic [DW-1:0]                 deg_q, deg_d, iss_q, iss_d;
  logic [DW-1:0]                 pend_idx_q, pend_idx_d, hit_q, hit_d;
  logic                          pend_q, pend_d;
  logic                          out_vld_q, out_vld_d;
  logic                          op_done, bad_vtx, full, hit;
  logic [DW-1:0]                 wslot, rslot;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= alet_pkg::S_CLR;
      clr_q     <= '0;
      phase_q   <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      phase_q   <= phase_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    to_q       <= to_d;
    dir_q      <= dir_d;
    wt_q       <= wt_d;
    from_q     <= from_d;
    base_q     <= base_d;
    deg_q      <= deg_d;
    iss_q      <= iss_d;
    pend_idx_q <= pend_idx_d;
    hit_q      <= hit_d;
    st_q       <= st_d;
    mst_q      <= mst_d;
    out_st_q   <= out_st_d;
    out_mst_q  <= out_mst_d;
  end

  // Shared compare and address terms
  assign bad_vtx = (32'(src_q) >= 32'(vcount_i)) || (32'(src_q) >= 32'(MAX_VERTICES)) ||
                   (32'(dst_q) >= 32'(vcount_i)) || (32'(dst_q) >= 32'(MAX_VERTICES));
  assign full    = (32'(deg_rdata_i) >= 32'(mdeg_i)) ||
                   (32'(deg_rdata_i) >= 32'(MAX_DEGREE));
  assign hit     = pend_q && (nb_rdata_i == to_q);
  assign wslot   = (state_q == alet_pkg::S_MWR) ? hit_q : deg_rdata_i;
  assign rslot   = (state_q == alet_pkg::S_MRD) ? (deg_q - DW'(1)) : iss_q;

  assign nb_waddr_o  = base_q + AW'(wslot);
  assign nb_raddr_o  = base_q + AW'(rslot);
  assign deg_raddr_o = from_q;
  assign in_ready_o  = (state_q == alet_pkg::S_IDLE);
  assign out_valid_o     = out_vld_q;
  assign status_o        = out_st_q;
  assign mirror_status_o = out_mst_q;

  // Sequence one request
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    phase_d    = phase_q;
    pend_d     = pend_q;
    kind_d     = kind_q;
    src_d      = src_q;
    dst_d      = dst_q;
    to_d       = to_q;
    dir_d      = dir_q;
    wt_d       = wt_q;
    from_d     = from_q;
    base_d     = base_q;
    deg_d      = deg_q;
    iss_d      = iss_q;
    pend_idx_d = pend_idx_q;
    hit_d      = hit_q;
    st_d       = st_q;
    mst_d      = mst_q;
    out_st_d   = out_st_q;
    out_mst_d  = out_mst_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    op_done    = 1'b0;
    op_st      = alet_pkg::ST_DONE;
    ctl_o      = '0;
    deg_waddr_o = from_q;
    deg_wdata_o = '0;
    nb_wdata_o  = to_q;
    wt_wdata_o  = wt_q;

    unique case (state_q)
      alet_pkg::S_CLR: begin
        // zero one degree entry a cycle
        ctl_o.deg_we = 1'b1;
        deg_waddr_o  = clr_q;
        if (clr_q == VW'(MAX_VERTICES - 1)) begin
          state_d = alet_pkg::S_IDLE;
        end else begin
          clr_d = clr_q + VW'(1);
        end
      end
      alet_pkg::S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          src_d   = source_i;
          dst_d   = target_i;
          dir_d   = directed_i;
          wt_d    = weight_i;
          phase_d = 1'b0;
          st_d    = alet_pkg::ST_DONE;
          mst_d   = alet_pkg::ST_DONE;
          state_d = alet_pkg::S_CHECK;
        end
      end
      alet_pkg::S_CHECK: begin
        if (bad_vtx) begin
          st_d    = alet_pkg::ST_RANGE;
          state_d = alet_pkg::S_FIN;
        end else begin
          from_d  = VW'(src_q);
          to_d    = dst_q;
          state_d = alet_pkg::S_DRD;
        end
      end
      alet_pkg::S_DRD: begin
        // degree read is in flight; form the list base
        base_d  = AW'(from_q) * AW'(MAX_DEGREE);
        state_d = alet_pkg::S_DCHK;
      end
      alet_pkg::S_DCHK: begin
        deg_d = deg_rdata_i;
        if (!kind_q) begin
          // append at the end of the list
          op_done = 1'b1;
          if (full) begin
            op_st = alet_pkg::ST_FULL;
          end else begin
            ctl_o.nb_we  = 1'b1;
            ctl_o.wt_we  = weighted_i;
            ctl_o.deg_we = 1'b1;
            deg_wdata_o  = deg_rdata_i + DW'(1);
          end
        end else begin
          iss_d   = '0;
          pend_d  = 1'b0;
          state_d = alet_pkg::S_SRCH;
        end
      end
      alet_pkg::S_SRCH: begin
        // issue one slot read a cycle, compare the previous one
        if (hit) begin
          hit_d   = pend_idx_q;
          pend_d  = 1'b0;
          state_d = alet_pkg::S_MRD;
        end else if (iss_q == deg_q) begin
          pend_d  = 1'b0;
          op_done = 1'b1;
          op_st   = alet_pkg::ST_NOTFOUND;
        end else begin
          pend_d     = 1'b1;
          pend_idx_d = iss_q;
          iss_d      = iss_q + DW'(1);
        end
      end
      alet_pkg::S_MRD: begin
        state_d = alet_pkg::S_MWR;
      end
      alet_pkg::S_MWR: begin
        // move the last slot into the gap
        ctl_o.nb_we  = 1'b1;
        ctl_o.wt_we  = weighted_i;
        ctl_o.deg_we = 1'b1;
        nb_wdata_o   = nb_rdata_i;
        wt_wdata_o   = wt_rdata_i;
        deg_wdata_o  = deg_q - DW'(1);
        op_done      = 1'b1;
      end
      alet_pkg::S_FIN: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          out_st_d  = st_q;
          out_mst_d = mst_q;
          state_d   = alet_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = alet_pkg::S_IDLE;
      end
    endcase

    // Record the edge result, then go on to the mirror edge or finish
    if (op_done) begin
      if (!phase_q) begin
        st_d = op_st;
        if ((op_st == alet_pkg::ST_DONE) && !dir_q) begin
          phase_d = 1'b1;
          from_d  = VW'(dst_q);
          to_d    = src_q;
          state_d = alet_pkg::S_DRD;
        end else begin
          state_d = alet_pkg::S_FIN;
        end
      end else begin
        mst_d   = op_st;
        state_d = alet_pkg::S_FIN;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == alet_pkg::S_IDLE) |-> (ctl_o == '0))
    else $error("table write while idle");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == alet_pkg::S_SRCH) |-> (iss_q <= deg_q))
    else $error("search ran past the list end");

  a_remove_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == alet_pkg::S_MWR) |-> (deg_q != '0))
    else $error("removal from an empty list");

  a_mirror_undirected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> !dir_q)
    else $error("mirror edge on a directed request");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == alet_pkg::S_FIN))
    else $error("result word loaded outside finish");
`endif

endmodule

// ===== design/adjacency_list_edge_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacency list edge table
// Bounded per-vertex neighbor lists with insert and remove of (mirrored)
// edges and optional edge weights.
// ----------------------------------------------------------------------------
// One request is in work at a time and the request channel is not ready
// meanwhile; a finished status word waits in an output register, so the next
// request is taken while it is still unclaimed. An insert runs a range check,
// a degree read and the append before the status word; a remove runs the
// range check, the degree read, the neighbor search and, on a match, a read
// of the last slot and its move into the gap. The mirror edge of an
// undirected request repeats the steps from the degree read on; the neighbor
// search reads and compares one slot a cycle through the neighbor memory
// read port. After reset the degree table is cleared one vertex a cycle,
// during which no request is taken; configuration writes are taken at any
// time and must only be issued while the table is idle.
module adjacency_list_edge_table #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  alet_req_if.sink                             req_i,
  alet_rsp_if.source                           rsp_o,
  input  logic                                 cfg_we_i,
  input  logic [alet_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [alet_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int AW = $clog2(MAX_VERTICES * MAX_DEGREE);

  logic [alet_pkg::VCNT_W-1:0] vcount_q;
  logic [alet_pkg::MDEG_W-1:0] mdeg_q;
  logic                        weighted_q;

  alet_pkg::mem_ctl_t            ctl;
  alet_pkg::status_e             status, mirror_status;
  logic [VW-1:0]                 deg_waddr, deg_raddr;
  logic [DW-1:0]                 deg_wdata, deg_rdata;
  logic [AW-1:0]                 nb_waddr, nb_raddr;
  logic [alet_pkg::VTX_W-1:0]    nb_wdata, nb_rdata;
  logic [alet_pkg::WEIGHT_W-1:0] wt_wdata, wt_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= alet_pkg::VCNT_W'(64);
      mdeg_q     <= alet_pkg::MDEG_W'(16);
      weighted_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        alet_pkg::CFG_VERTEX_COUNT: vcount_q   <= cfg_wdata_i[alet_pkg::VCNT_W-1:0];
        alet_pkg::CFG_MAX_DEGREE:   mdeg_q     <= cfg_wdata_i[alet_pkg::MDEG_W-1:0];
        alet_pkg::CFG_WEIGHTED:     weighted_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Request sequencer
  alet_seq #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vcount_i        (vcount_q),
    .mdeg_i          (mdeg_q),
    .weighted_i      (weighted_q),
    .in_valid_i      (req_i.valid),
    .in_ready_o      (req_i.ready),
    .kind_i          (req_i.kind),
    .source_i        (req_i.source_vtx),
    .target_i        (req_i.target),
    .directed_i      (req_i.directed),
    .weight_i        (req_i.weight),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .status_o        (status),
    .mirror_status_o (mirror_status),
    .ctl_o           (ctl),
    .deg_waddr_o     (deg_waddr),
    .deg_wdata_o     (deg_wdata),
    .deg_raddr_o     (deg_raddr),
    .deg_rdata_i     (deg_rdata),
    .nb_waddr_o      (nb_waddr),
    .nb_wdata_o      (nb_wdata),
    .wt_wdata_o      (wt_wdata),
    .nb_raddr_o      (nb_raddr),
    .nb_rdata_i      (nb_rdata),
    .wt_rdata_i      (wt_rdata)
  );

  assign rsp_o.status        = status;
  assign rsp_o.mirror_status = mirror_status;

  // Degree, neighbor and weight storage
  alet_tables #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_tables (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .deg_waddr_i (deg_waddr),
    .deg_wdata_i (deg_wdata),
    .deg_raddr_i (deg_raddr),
    .deg_rdata_o (deg_rdata),
    .nb_waddr_i  (nb_waddr),
    .nb_wdata_i  (nb_wdata),
    .wt_wdata_i  (wt_wdata),
    .nb_raddr_i  (nb_raddr),
    .nb_rdata_o  (nb_rdata),
    .wt_rdata_o  (wt_rdata)
  );

endmodule
